>>> rtl/rcd_pkg.sv
package rcd_pkg;

    localparam int DW = 64;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [63:0] LN2_Q60      = 64'h0B17217F7D1CF79B;
    localparam logic [63:0] GAIN_INV_Q60 = 64'd700114967507363238;
    localparam logic [15:0] RADIUS_RESET = 16'd6371;

    typedef struct packed {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] z;
    } xyz_t;

    typedef struct packed {
        xyz_t       v;
        logic [7:0] e;
    } lnp_t;

    typedef struct packed {
        logic [DW-1:0]          sl;
        logic [DW-1:0]          el;
        logic [DW-1:0]          dlon;
        logic [DW-1:0]          dpsi;
        logic [DW-1:0]          course;
        logic [DW-1:0]          cos_sl;
        logic [DW-1:0]          qs;
        logic [DW-1:0]          qe;
        logic [DW-1:0]          num;
        logic [DW-1:0]          pe;
        logic [DW-1:0]          dc;
        logic [DW-1:0]          rem;
        logic [3:0][DW-1:0]     lx;
        logic [3:0][DW-1:0]     ly;
        logic [3:0][DW-1:0]     lz;
        logic [3:0][7:0]        le;
        logic                   sl_mult;
        logic                   el_mult;
        logic [2*DW-1:0]        pa;
        logic [2*DW-1:0]        pb;
        logic [31:0]            eq_len;
        logic                   eq_sat;
        logic [31:0]            quo;
        logic                   dsat;
        logic [31:0]            fin_len;
        logic                   fin_sat;
    } item_t;

    // rounded conversion from 60 fraction bits
    function automatic logic [63:0] from_q60(input logic [63:0] v, input int f);
        return (v + (64'd1 << (59 - f))) >> (60 - f);
    endfunction

    // atan(2^-i) or atanh(2^-i) series, 60 fraction bits
    function automatic logic [63:0] arc_series(input int i, input bit alt);
        logic [63:0] sum;
        logic [63:0] t;
        int          e;
        sum = '0;
        for (int kk = 0; kk < 64; kk++) begin
            e = i * (2 * kk + 1);
            if (e <= 60) begin
                t = (64'd1 << (60 - e)) / 64'(2 * kk + 1);
                if (alt && (kk % 2 == 1)) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_q(input int i, input int f);
        if (i == 0) begin
            return from_q60(PI_Q60 >> 2, f);
        end
        return from_q60(arc_series(i, 1'b1), f);
    endfunction

    function automatic logic [63:0] atanh_q(input int i, input int f);
        if (i == 0) begin
            return '0;
        end
        return from_q60(arc_series(i, 1'b0), f);
    endfunction

    // hyperbolic shift index of step n, with 4, 13, 40 taken twice
    function automatic int hyp_index(input int n);
        int i;
        int rep_at;
        bit rep;
        i = 1;
        rep_at = 4;
        rep = 1'b0;
        for (int m = 0; m < n; m++) begin
            if (i == rep_at && !rep) begin
                rep = 1'b1;
            end else begin
                if (i == rep_at) begin
                    rep_at = 3 * rep_at + 1;
                    rep = 1'b0;
                end
                i++;
            end
        end
        return i % 64;
    endfunction

    function automatic xyz_t rot_step(input xyz_t d, input int i, input logic [DW-1:0] atn);
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        xyz_t r;
        x = d.x;
        y = d.y;
        z = d.z;
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
            r.x = x - dx;
            r.y = y + dy;
            r.z = z - atn;
        end else begin
            r.x = x + dx;
            r.y = y - dy;
            r.z = z + atn;
        end
        return r;
    endfunction

    function automatic xyz_t vec_step(input xyz_t d, input int i, input logic [DW-1:0] atn);
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        xyz_t r;
        x = d.x;
        y = d.y;
        z = d.z;
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
            r.x = x + dx;
            r.y = y - dy;
            r.z = z + atn;
        end else begin
            r.x = x - dx;
            r.y = y + dy;
            r.z = z - atn;
        end
        return r;
    endfunction

    function automatic xyz_t hyp_step(input xyz_t d, input int i, input logic [DW-1:0] ath);
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        xyz_t r;
        x = d.x;
        y = d.y;
        z = d.z;
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
            r.x = x + dx;
            r.y = y + dy;
            r.z = z - ath;
        end else begin
            r.x = x - dx;
            r.y = y - dy;
            r.z = z + ath;
        end
        return r;
    endfunction

    // normalize v >= 1 to [0.5, 1) and set up hyperbolic vectoring
    function automatic lnp_t ln_prep(input logic [DW-1:0] v, input int f);
        int          nb;
        logic [DW-1:0] m;
        logic [DW-1:0] one;
        lnp_t        r;
        nb = 0;
        one = 64'd1 << f;
        for (int b = 0; b < DW; b++) begin
            if (v[b]) begin
                nb = b + 1;
            end
        end
        if (nb > f) begin
            m = v >> (nb - f);
        end else begin
            m = v << (f - nb);
        end
        r.v.x = m + one;
        r.v.y = m - one;
        r.v.z = '0;
        r.e = 8'(nb - f);
        return r;
    endfunction

endpackage

>>> rtl/rhumb_course_and_distance_top.sv
// throughput: one word per cycle; the pipeline advances whenever the output skid is empty
// pipeline length set by three circular and one hyperbolic cordic pass plus a 32-step radix-2 divider
// reset: synchronous active-low aresetn clears all valid bits and loads the radius with 6371
module rhumb_course_and_distance_top #(
    parameter int ANGLE_FRAC_BITS  = 29,
    parameter int LENGTH_FRAC_BITS = 8,
    parameter int CORDIC_STEPS     = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_start_lat,
    input  logic signed [30:0] s_end_lat,
    input  logic signed [31:0] s_start_lon,
    input  logic signed [31:0] s_end_lon,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_course_angle,
    output logic [31:0]        m_track_length,
    output logic               m_length_saturated
);

    localparam int F = ANGLE_FRAC_BITS;
    localparam int L = LENGTH_FRAC_BITS;
    localparam int N = CORDIC_STEPS;
    localparam int DW = rcd_pkg::DW;

    localparam logic signed [DW-1:0] K_PI   = rcd_pkg::from_q60(rcd_pkg::PI_Q60, F);
    localparam logic signed [DW-1:0] K_HP   = rcd_pkg::from_q60(rcd_pkg::PI_Q60 >> 1, F);
    localparam logic signed [DW-1:0] K_2PI  = rcd_pkg::from_q60(rcd_pkg::PI_Q60 << 1, F);
    localparam logic signed [DW-1:0] K_LN2  = rcd_pkg::from_q60(rcd_pkg::LN2_Q60, F);
    localparam logic signed [DW-1:0] K_GAIN = rcd_pkg::from_q60(rcd_pkg::GAIN_INV_Q60, F);
    localparam logic signed [DW-1:0] K_ONE  = 64'sd1 <<< F;

    // reciprocal of pi/2 for the multiple-of-pi/2 test on latitudes
    localparam int SQ = 31 + F;
    localparam logic [127:0] RECIP_W = (128'd1 << SQ) / 128'(K_HP);
    localparam logic [31:0]  RECIP   = RECIP_W[31:0];

    localparam int SH = 2 * F - L;

    localparam int S_ROT = 1;
    localparam int S_LNP = S_ROT + N;
    localparam int S_HYP = S_LNP + 1;
    localparam int S_PSI = S_HYP + N;
    localparam int S_AT0 = S_PSI + 1;
    localparam int S_ATS = S_AT0 + 1;
    localparam int S_CRS = S_ATS + N;
    localparam int S_COS = S_CRS + 1;
    localparam int S_MUL = S_COS + N;
    localparam int S_PAR = S_MUL + 1;
    localparam int S_SUM = S_PAR + 1;
    localparam int S_DIV = S_SUM + 1;
    localparam int S_END = S_DIV + 32;
    localparam int NST   = S_END + 1;

    logic [15:0]           radius_reg;
    rcd_pkg::item_t        stage_reg  [NST];
    rcd_pkg::item_t        stage_next [NST];
    logic [NST-1:0]        vld_reg;
    logic                  adv;
    logic                  take;
    logic                  out_vld_reg;
    logic [31:0]           out_course_reg;
    logic [31:0]           out_len_reg;
    logic                  out_sat_reg;
    logic                  skid_vld_reg;
    logic [31:0]           skid_course_reg;
    logic [31:0]           skid_len_reg;
    logic                  skid_sat_reg;

    assign adv     = !skid_vld_reg;
    assign s_ready = adv;
    assign take    = adv && vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= rcd_pkg::RADIUS_RESET;
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    genvar k;
    for (k = 0; k < NST; k++) begin : g_st
        if (k == 0) begin : g_in
            always_comb begin
                logic signed [DW-1:0] sl;
                logic signed [DW-1:0] el;
                logic signed [DW-1:0] so;
                logic signed [DW-1:0] eo;
                logic signed [DW-1:0] dl;
                logic signed [DW-1:0] a0;
                logic signed [DW-1:0] a1;
                rcd_pkg::item_t n;
                n = '0;
                sl = 64'(s_start_lat);
                el = 64'(s_end_lat);
                so = 64'(s_start_lon);
                eo = 64'(s_end_lon);
                dl = eo - so;
                if (dl > K_PI) begin
                    dl = dl - K_2PI;
                end else if (dl < -K_PI) begin
                    dl = dl + K_2PI;
                end
                a0 = (sl < 0) ? -sl : sl;
                a1 = (el < 0) ? -el : el;
                n.qs = 64'(a0[30:0]) * 64'(RECIP);
                n.qe = 64'(a1[30:0]) * 64'(RECIP);
                if (a0 > K_HP) begin
                    a0 = K_HP;
                end
                if (a1 > K_HP) begin
                    a1 = K_HP;
                end
                n.sl = sl;
                n.el = el;
                n.dlon = dl;
                n.lx[0] = K_GAIN;
                n.lz[0] = a0;
                n.lx[1] = K_GAIN;
                n.lz[1] = a1;
                stage_next[k] = n;
            end
        end else if (k < S_LNP) begin : g_rot
            localparam int I = (k - S_ROT) % 64;
            localparam logic [DW-1:0] ATN = rcd_pkg::atan_q(I, F);
            always_comb begin
                rcd_pkg::item_t n;
                rcd_pkg::xyz_t  r0;
                rcd_pkg::xyz_t  r1;
                logic signed [DW-1:0] as;
                logic signed [DW-1:0] ae;
                logic [DW-1:0] q0;
                logic [DW-1:0] q1;
                n = stage_reg[k-1];
                r0 = rcd_pkg::rot_step({n.lx[0], n.ly[0], n.lz[0]}, I, ATN);
                r1 = rcd_pkg::rot_step({n.lx[1], n.ly[1], n.lz[1]}, I, ATN);
                {n.lx[0], n.ly[0], n.lz[0]} = r0;
                {n.lx[1], n.ly[1], n.lz[1]} = r1;
                if (k == S_ROT) begin
                    as = ($signed(n.sl) < 0) ? -$signed(n.sl) : $signed(n.sl);
                    ae = ($signed(n.el) < 0) ? -$signed(n.el) : $signed(n.el);
                    q0 = n.qs >> SQ;
                    q1 = n.qe >> SQ;
                    n.sl_mult = (q0 * K_HP == as) || ((q0 + 64'd1) * K_HP == as);
                    n.el_mult = (q1 * K_HP == ae) || ((q1 + 64'd1) * K_HP == ae);
                end
                stage_next[k] = n;
            end
        end else if (k == S_LNP) begin : g_lnp
            always_comb begin
                rcd_pkg::item_t n;
                rcd_pkg::lnp_t  p;
                logic signed [DW-1:0] c;
                logic signed [DW-1:0] s;
                logic [3:0][DW-1:0] v;
                n = stage_reg[k-1];
                for (int j = 0; j < 2; j++) begin
                    c = n.lx[j];
                    s = n.ly[j];
                    if (j == 0) begin
                        n.cos_sl = (c < 0) ? '0 : c;
                    end
                    if (c < 1) begin
                        c = 1;
                    end
                    if (s < 0) begin
                        s = 0;
                    end
                    v[2*j]   = K_ONE + s;
                    v[2*j+1] = c;
                end
                for (int j = 0; j < 4; j++) begin
                    p = rcd_pkg::ln_prep(v[j], F);
                    {n.lx[j], n.ly[j], n.lz[j]} = p.v;
                    n.le[j] = p.e;
                end
                stage_next[k] = n;
            end
        end else if (k < S_PSI) begin : g_hyp
            localparam int I = rcd_pkg::hyp_index(k - S_HYP);
            localparam logic [DW-1:0] ATH = rcd_pkg::atanh_q(I, F);
            always_comb begin
                rcd_pkg::item_t n;
                n = stage_reg[k-1];
                for (int j = 0; j < 4; j++) begin
                    {n.lx[j], n.ly[j], n.lz[j]} =
                        rcd_pkg::hyp_step({n.lx[j], n.ly[j], n.lz[j]}, I, ATH);
                end
                stage_next[k] = n;
            end
        end else if (k == S_PSI) begin : g_psi
            always_comb begin
                rcd_pkg::item_t n;
                logic signed [DW-1:0] ln [4];
                logic signed [DW-1:0] ps;
                logic signed [DW-1:0] pe;
                n = stage_reg[k-1];
                for (int j = 0; j < 4; j++) begin
                    ln[j] = ($signed(n.lz[j]) <<< 1)
                          + $signed({{(DW-8){n.le[j][7]}}, n.le[j]}) * K_LN2;
                end
                ps = ln[0] - ln[1];
                pe = ln[2] - ln[3];
                if (n.sl == '0) begin
                    ps = 0;
                end else if ($signed(n.sl) < 0) begin
                    ps = -ps;
                end
                if (n.el == '0) begin
                    pe = 0;
                end else if ($signed(n.el) < 0) begin
                    pe = -pe;
                end
                n.dpsi = pe - ps;
                stage_next[k] = n;
            end
        end else if (k == S_AT0) begin : g_at0
            always_comb begin
                rcd_pkg::item_t n;
                logic signed [DW-1:0] x;
                logic signed [DW-1:0] y;
                logic signed [DW-1:0] z;
                n = stage_reg[k-1];
                x = n.dpsi;
                y = n.dlon;
                z = 0;
                if (x < 0) begin
                    z = (y >= 0) ? K_PI : -K_PI;
                    x = -x;
                    y = -y;
                end
                n.lx[0] = x;
                n.ly[0] = y;
                n.lz[0] = z;
                stage_next[k] = n;
            end
        end else if (k < S_CRS) begin : g_ats
            localparam int I = (k - S_ATS) % 64;
            localparam logic [DW-1:0] ATN = rcd_pkg::atan_q(I, F);
            always_comb begin
                rcd_pkg::item_t n;
                n = stage_reg[k-1];
                {n.lx[0], n.ly[0], n.lz[0]} =
                    rcd_pkg::vec_step({n.lx[0], n.ly[0], n.lz[0]}, I, ATN);
                stage_next[k] = n;
            end
        end else if (k == S_CRS) begin : g_crs
            always_comb begin
                rcd_pkg::item_t n;
                logic signed [DW-1:0] crs;
                logic signed [DW-1:0] ang;
                n = stage_reg[k-1];
                if (n.dlon == '0) begin
                    crs = ($signed(n.dpsi) < 0) ? K_PI : 64'sd0;
                end else begin
                    crs = n.lz[0];
                    if (crs < 0) begin
                        crs = crs + K_2PI;
                    end
                    if (crs >= K_2PI) begin
                        crs = crs - K_2PI;
                    end
                end
                // pole overrides, later ones win
                if ($signed(n.sl) == K_HP && !n.el_mult) begin
                    crs = K_PI;
                end
                if ($signed(n.sl) == -K_HP && !n.el_mult) begin
                    crs = 0;
                end
                if ($signed(n.el) == K_HP && !n.sl_mult) begin
                    crs = 0;
                end
                if ($signed(n.el) == -K_HP && !n.sl_mult) begin
                    crs = K_PI;
                end
                n.course = crs;
                ang = crs;
                if (ang > K_PI) begin
                    ang = ang - K_2PI;
                end
                if (ang < 0) begin
                    ang = -ang;
                end
                if (ang > K_HP) begin
                    ang = K_PI - ang;
                end
                if (ang < 0) begin
                    ang = 0;
                end
                n.lx[0] = K_GAIN;
                n.ly[0] = '0;
                n.lz[0] = ang;
                stage_next[k] = n;
            end
        end else if (k < S_MUL) begin : g_cos
            localparam int I = (k - S_COS) % 64;
            localparam logic [DW-1:0] ATN = rcd_pkg::atan_q(I, F);
            always_comb begin
                rcd_pkg::item_t n;
                n = stage_reg[k-1];
                {n.lx[0], n.ly[0], n.lz[0]} =
                    rcd_pkg::rot_step({n.lx[0], n.ly[0], n.lz[0]}, I, ATN);
                stage_next[k] = n;
            end
        end else if (k == S_MUL) begin : g_mul
            always_comb begin
                rcd_pkg::item_t n;
                logic signed [DW-1:0] dl;
                logic signed [DW-1:0] ad;
                logic [DW-1:0] p;
                n = stage_reg[k-1];
                n.dc = n.lx[0];
                dl = $signed(n.el) - $signed(n.sl);
                ad = (dl < 0) ? -dl : dl;
                p = 64'(ad[32:0]) * 64'(radius_reg);
                n.num = p << L;
                ad = ($signed(n.dlon) < 0) ? -$signed(n.dlon) : $signed(n.dlon);
                n.pe = 64'(ad[33:0]) * 64'(radius_reg);
                stage_next[k] = n;
            end
        end else if (k == S_PAR) begin : g_par
            always_comb begin
                rcd_pkg::item_t n;
                n = stage_reg[k-1];
                n.pa = 128'(n.pe[31:0]) * 128'(n.cos_sl[F+1:0]);
                n.pb = 128'(n.pe[63:32]) * 128'(n.cos_sl[F+1:0]);
                n.dsat = !($signed(n.dc) > 0)
                      || ({64'd0, n.num} >= ({64'd0, n.dc} << 32));
                n.rem = n.num;
                n.quo = '0;
                stage_next[k] = n;
            end
        end else if (k == S_SUM) begin : g_sum
            always_comb begin
                rcd_pkg::item_t n;
                logic [2*DW-1:0] prod;
                n = stage_reg[k-1];
                prod = (n.pa + (n.pb << 32)) >> SH;
                n.eq_sat = |prod[2*DW-1:32];
                n.eq_len = prod[31:0];
                stage_next[k] = n;
            end
        end else if (k < S_END) begin : g_div
            localparam int B = 31 - (k - S_DIV);
            always_comb begin
                rcd_pkg::item_t n;
                logic [2*DW-1:0] sub;
                n = stage_reg[k-1];
                sub = {64'd0, n.dc} << B;
                if ({64'd0, n.rem} >= sub) begin
                    n.rem = n.rem - sub[DW-1:0];
                    n.quo[B] = 1'b1;
                end
                stage_next[k] = n;
            end
        end else begin : g_end
            always_comb begin
                rcd_pkg::item_t n;
                logic sat;
                logic [31:0] len;
                n = stage_reg[k-1];
                if (n.sl == n.el) begin
                    sat = n.eq_sat;
                    len = n.eq_len;
                end else begin
                    sat = n.dsat;
                    len = n.quo;
                end
                n.fin_sat = sat;
                n.fin_len = sat ? 32'hFFFF_FFFF : len;
                stage_next[k] = n;
            end
        end
    end

    // output word register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            if (skid_vld_reg) begin
                out_vld_reg    <= 1'b1;
                out_course_reg <= skid_course_reg;
                out_len_reg    <= skid_len_reg;
                out_sat_reg    <= skid_sat_reg;
                skid_vld_reg   <= 1'b0;
            end else begin
                out_vld_reg <= take;
                if (take) begin
                    out_course_reg <= stage_reg[NST-1].course[31:0];
                    out_len_reg    <= stage_reg[NST-1].fin_len;
                    out_sat_reg    <= stage_reg[NST-1].fin_sat;
                end
            end
        end else if (take) begin
            skid_vld_reg    <= 1'b1;
            skid_course_reg <= stage_reg[NST-1].course[31:0];
            skid_len_reg    <= stage_reg[NST-1].fin_len;
            skid_sat_reg    <= stage_reg[NST-1].fin_sat;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_course_angle     = out_course_reg;
    assign m_track_length     = out_len_reg;
    assign m_length_saturated = out_sat_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_ready))
        else $error("skid filled while output was free");

    a_sat_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_length_saturated) |-> (m_track_length == 32'hFFFF_FFFF))
        else $error("saturated word without clamped length");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NST-1] && !adv) |=> vld_reg[NST-1])
        else $error("last stage word lost during stall");

endmodule
